[src/fac_pkg.sv]
// shared types and constants for the frame allocator with clock replacement
`default_nettype none
package fac_pkg;

	localparam int NUM_FRAMES = 64;
	localparam int OWNER_BITS = 8;
	localparam int VPAGE_BITS = 16;
	localparam int FRAME_W    = $clog2(NUM_FRAMES);
	localparam int COUNT_W    = $clog2(NUM_FRAMES + 1);
	localparam int VISIT_W    = $clog2(2 * NUM_FRAMES);

	typedef logic [FRAME_W-1:0]    frame_t;
	typedef logic [COUNT_W-1:0]    count_t;
	typedef logic [VISIT_W-1:0]    visit_t;
	typedef logic [OWNER_BITS-1:0] owner_t;
	typedef logic [VPAGE_BITS-1:0] vpage_t;

	typedef enum logic [2:0] {
		REQ_ALLOC   = 3'd0,
		REQ_RELEASE = 3'd1,
		REQ_UNLOCK  = 3'd2,
		REQ_MARK    = 3'd3,
		REQ_OWNER   = 3'd4
	} req_e_t;

	typedef enum logic [2:0] {
		ST_FREE_LIST  = 3'd0,
		ST_EVICTED    = 3'd1,
		ST_ALL_LOCKED = 3'd2,
		ST_DONE       = 3'd3,
		ST_ERROR      = 3'd4
	} status_e_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_POP,
		S_RELEASE,
		S_SWEEP,
		S_EVICT,
		S_RESULT
	} state_e_t;

	// commands into the frame flag table and clock hand unit
	typedef struct packed {
		logic   take;
		logic   release_frame;
		logic   unlock;
		logic   mark;
		logic   mark_dirty;
		logic   sweep_start;
		logic   sweep_step;
		logic   evict_commit;
		frame_t idx;
	} flag_cmd_t;

	// status back from the flag table
	typedef struct packed {
		logic   free_bit;
		logic   locked_bit;
		logic   hit;
		logic   dirty_at_ptr;
		logic   last_visit;
		frame_t ptr;
	} flag_sts_t;

	typedef struct packed {
		frame_t    grant;
		status_e_t status;
		owner_t    m_owner;
		vpage_t    m_vpage;
		logic      m_valid;
		logic      writeback;
	} result_t;

endpackage
`default_nettype wire

[src/fac_map_ram.sv]
// owner and virtual page storage, one write port and one registered read port
`default_nettype none
module fac_map_ram
	import fac_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   we_owner,
	input  wire logic   we_vpage,
	input  wire frame_t waddr,
	input  wire owner_t wowner,
	input  wire vpage_t wvpage,
	input  wire frame_t raddr,
	output logic        [OWNER_BITS-1:0] rowner,
	output logic        [VPAGE_BITS-1:0] rvpage
);

	owner_t owner_mem [NUM_FRAMES];
	vpage_t vpage_mem [NUM_FRAMES];
	owner_t rowner_q;
	vpage_t rvpage_q;

	always_ff @(posedge clk) begin
		if (we_owner) begin
			owner_mem[waddr] <= wowner;
		end
		if (we_vpage) begin
			vpage_mem[waddr] <= wvpage;
		end
		rowner_q <= owner_mem[raddr];
		rvpage_q <= vpage_mem[raddr];
	end

	assign rowner = rowner_q;
	assign rvpage = rvpage_q;

endmodule
`default_nettype wire

[src/fac_free_stack.sv]
// lifo of free frame numbers with registered top read
`default_nettype none
module fac_free_stack
	import fac_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   pop,
	input  wire logic   push,
	input  wire frame_t push_frame,
	output count_t      count,
	output frame_t      top_frame
);

	frame_t                  stack_mem [NUM_FRAMES];
	logic [NUM_FRAMES-1:0]   slot_wr_q;
	count_t                  count_q;
	count_t                  pop_pos;
	frame_t                  pop_idx;
	frame_t                  push_idx;
	frame_t                  rd_q;
	frame_t                  ridx_q;
	logic                    rvalid_q;

	assign pop_pos  = count_q - 1'b1;
	assign pop_idx  = pop_pos[FRAME_W-1:0];
	assign push_idx = count_q[FRAME_W-1:0];

	// slots never written since reset hold the frames in descending order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_wr_q <= '0;
			count_q   <= COUNT_W'(NUM_FRAMES);
		end else begin
			if (push) begin
				slot_wr_q[push_idx] <= 1'b1;
				count_q             <= count_q + 1'b1;
			end else if (pop) begin
				count_q <= pop_pos;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			stack_mem[push_idx] <= push_frame;
		end
		rd_q     <= stack_mem[pop_idx];
		rvalid_q <= slot_wr_q[pop_idx];
		ridx_q   <= pop_idx;
	end

	assign count     = count_q;
	assign top_frame = rvalid_q ? rd_q : (FRAME_W'(NUM_FRAMES - 1) - ridx_q);

endmodule
`default_nettype wire

[src/fac_flags.sv]
// per-frame flag bits and the clock hand sweep unit
`default_nettype none
module fac_flags
	import fac_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire flag_cmd_t cmd,
	output flag_sts_t      sts
);

	logic [NUM_FRAMES-1:0] free_q;
	logic [NUM_FRAMES-1:0] locked_q;
	logic [NUM_FRAMES-1:0] ref_q;
	logic [NUM_FRAMES-1:0] dirty_q;
	frame_t                hand_q;
	frame_t                ptr_q;
	visit_t                visit_q;
	frame_t                ptr_next;
	logic                  hit;

	assign ptr_next = (ptr_q == FRAME_W'(NUM_FRAMES - 1)) ? '0 : ptr_q + 1'b1;
	assign hit      = !ref_q[ptr_q] && !locked_q[ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q   <= '1;
			locked_q <= '0;
			ref_q    <= '0;
			dirty_q  <= '0;
			hand_q   <= '0;
			ptr_q    <= '0;
			visit_q  <= '0;
		end else begin
			if (cmd.take) begin
				free_q[cmd.idx]   <= 1'b0;
				locked_q[cmd.idx] <= 1'b1;
				ref_q[cmd.idx]    <= 1'b0;
				dirty_q[cmd.idx]  <= 1'b0;
			end
			if (cmd.release_frame) begin
				free_q[cmd.idx]   <= 1'b1;
				locked_q[cmd.idx] <= 1'b0;
			end
			if (cmd.unlock) begin
				locked_q[cmd.idx] <= 1'b0;
			end
			if (cmd.mark) begin
				ref_q[cmd.idx] <= 1'b1;
				if (cmd.mark_dirty) begin
					dirty_q[cmd.idx] <= 1'b1;
				end
			end
			if (cmd.sweep_start) begin
				ptr_q   <= hand_q;
				visit_q <= '0;
			end
			// one frame visit per cycle; the pointer parks on the victim
			if (cmd.sweep_step) begin
				ref_q[ptr_q] <= 1'b0;
				if (!hit) begin
					ptr_q   <= ptr_next;
					visit_q <= visit_q + 1'b1;
				end
			end
			if (cmd.evict_commit) begin
				hand_q <= ptr_next;
			end
		end
	end

	assign sts.free_bit     = free_q[cmd.idx];
	assign sts.locked_bit   = locked_q[cmd.idx];
	assign sts.hit          = hit;
	assign sts.dirty_at_ptr = dirty_q[ptr_q];
	assign sts.last_visit   = (visit_q == VISIT_W'(2 * NUM_FRAMES - 1));
	assign sts.ptr          = ptr_q;

endmodule
`default_nettype wire

[src/frame_allocator_clock_replace_top.sv]
// top level of the frame allocator with free list and clock replacement
// usage:
// - request channel: in_valid / in_stall with req_type, frame, owner_id,
//   virtual_page and is_write; a transaction completes when in_valid is high
//   and in_stall is low
// - result channel: out_valid / out_stall, one result transaction per request
// - one request is worked on at a time; in_stall is high from the cycle after
//   acceptance until the request's result has been placed in the output register
// - unlock, access mark, owner change and error cases go from the execute state to the
//   result state, where the output register is loaded; allocate from the free list and
//   release pass the pop or release state in between; the next request is taken in idle
// - allocate with an empty free list runs the clock hand, one frame visit
//   per cycle through the flag table, visiting 1 to 128 frames; all-locked
//   comes after 128 visits
// - the output register holds a result while out_valid is high and out_stall
//   is high; the next request may be accepted meanwhile and waits at its end
//   until the register is free
// - reset: all frames free and unlocked, free list in ascending order with
//   frame 0 on top, clock hand at frame 0, no result pending; no clearing
//   pass is needed, the block accepts requests right after reset
`default_nettype none
module frame_allocator_clock_replace_top
	import fac_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [2:0]            req_type,
	input  wire logic [FRAME_W-1:0]    frame,
	input  wire logic [OWNER_BITS-1:0] owner_id,
	input  wire logic [VPAGE_BITS-1:0] virtual_page,
	input  wire logic                  is_write,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [FRAME_W-1:0]         granted_frame,
	output logic [2:0]                 status,
	output logic [OWNER_BITS-1:0]      mapping_owner,
	output logic [VPAGE_BITS-1:0]      mapping_virtual_page,
	output logic                       mapping_valid,
	output logic                       needs_writeback
);

	state_e_t  state_q, state_d;

	// captured request
	req_e_t    req_q;
	frame_t    frame_q;
	owner_t    owner_q;
	vpage_t    vpage_q;
	logic      write_q;

	// staged result and the output register
	result_t   res_q, res_d;
	logic      res_ld;
	result_t   out_q;
	logic      out_valid_q;
	logic      out_free;
	logic      out_ld;

	flag_cmd_t fcmd;
	flag_sts_t fsts;

	logic      pop, push;
	count_t    count;
	frame_t    top_frame;

	logic      we_owner, we_vpage;
	frame_t    waddr, raddr;
	owner_t    rowner;
	vpage_t    rvpage;

	fac_flags u_flags (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (fcmd),
		.sts    (fsts)
	);

	fac_free_stack u_stack (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop        (pop),
		.push       (push),
		.push_frame (frame_q),
		.count      (count),
		.top_frame  (top_frame)
	);

	fac_map_ram u_map (
		.clk      (clk),
		.we_owner (we_owner),
		.we_vpage (we_vpage),
		.waddr    (waddr),
		.wowner   (owner_q),
		.wvpage   (vpage_q),
		.raddr    (raddr),
		.rowner   (rowner),
		.rvpage   (rvpage)
	);

	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// mapping memory is read at the sweep pointer while sweeping, otherwise
	// at the requested frame; read data shows up in the following cycle
	assign raddr = (state_q == S_SWEEP) ? fsts.ptr : frame_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		fcmd     = '0;
		fcmd.idx = frame_q;
		pop      = 1'b0;
		push     = 1'b0;
		we_owner = 1'b0;
		we_vpage = 1'b0;
		waddr    = frame_q;
		res_d    = '0;
		res_d.status = ST_ERROR;
		res_ld   = 1'b0;
		out_ld   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				// every 6-bit frame number is in range with 64 frames
				state_d = S_RESULT;
				res_ld  = 1'b1;
				case (req_q)
					REQ_ALLOC: begin
						res_ld = 1'b0;
						if (count != '0) begin
							pop     = 1'b1;
							state_d = S_POP;
						end else begin
							fcmd.sweep_start = 1'b1;
							state_d          = S_SWEEP;
						end
					end
					REQ_RELEASE: begin
						if (!fsts.free_bit && count < COUNT_W'(NUM_FRAMES)) begin
							fcmd.release_frame = 1'b1;
							push               = 1'b1;
							res_ld             = 1'b0;
							state_d            = S_RELEASE;
						end
					end
					REQ_UNLOCK: begin
						if (!fsts.free_bit && fsts.locked_bit) begin
							fcmd.unlock  = 1'b1;
							res_d.status = ST_DONE;
						end
					end
					REQ_MARK: begin
						if (!fsts.free_bit) begin
							fcmd.mark       = 1'b1;
							fcmd.mark_dirty = write_q;
							res_d.status    = ST_DONE;
						end
					end
					REQ_OWNER: begin
						if (!fsts.free_bit) begin
							we_owner     = 1'b1;
							res_d.status = ST_DONE;
						end
					end
					default: begin
						res_d.status = ST_ERROR;
					end
				endcase
			end
			S_POP: begin
				fcmd.take    = 1'b1;
				fcmd.idx     = top_frame;
				we_owner     = 1'b1;
				we_vpage     = 1'b1;
				waddr        = top_frame;
				res_d.grant  = top_frame;
				res_d.status = ST_FREE_LIST;
				res_ld       = 1'b1;
				state_d      = S_RESULT;
			end
			S_RELEASE: begin
				res_d.status  = ST_DONE;
				res_d.m_owner = rowner;
				res_d.m_vpage = rvpage;
				res_d.m_valid = 1'b1;
				res_ld        = 1'b1;
				state_d       = S_RESULT;
			end
			S_SWEEP: begin
				fcmd.sweep_step = 1'b1;
				if (fsts.hit) begin
					state_d = S_EVICT;
				end else if (fsts.last_visit) begin
					res_d.status = ST_ALL_LOCKED;
					res_ld       = 1'b1;
					state_d      = S_RESULT;
				end
			end
			S_EVICT: begin
				// victim mapping comes out of the memory before it is overwritten
				fcmd.take         = 1'b1;
				fcmd.idx          = fsts.ptr;
				fcmd.evict_commit = 1'b1;
				we_owner          = 1'b1;
				we_vpage          = 1'b1;
				waddr             = fsts.ptr;
				res_d.grant       = fsts.ptr;
				res_d.status      = ST_EVICTED;
				res_d.m_owner     = rowner;
				res_d.m_vpage     = rvpage;
				res_d.m_valid     = 1'b1;
				res_d.writeback   = fsts.dirty_at_ptr;
				res_ld            = 1'b1;
				state_d           = S_RESULT;
			end
			S_RESULT: begin
				if (out_free) begin
					out_ld  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// request capture and result staging
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			req_q   <= req_e_t'(req_type);
			frame_q <= frame;
			owner_q <= owner_id;
			vpage_q <= virtual_page;
			write_q <= is_write;
		end
		if (res_ld) begin
			res_q <= res_d;
		end
		if (out_ld) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid            = out_valid_q;
	assign granted_frame        = out_q.grant;
	assign status               = out_q.status;
	assign mapping_owner        = out_q.m_owner;
	assign mapping_virtual_page = out_q.m_vpage;
	assign mapping_valid        = out_q.m_valid;
	assign needs_writeback      = out_q.writeback;

	// free list never holds more than every frame
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count <= COUNT_W'(NUM_FRAMES))
		else $error("free list count above frame total");

	// an eviction always names the mapping it removed
	a_evict_mapping: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EVICTED |-> mapping_valid)
		else $error("eviction without mapping");

	// writeback is only requested for an evicted frame
	a_wb_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && needs_writeback |-> status == ST_EVICTED)
		else $error("writeback outside eviction");

	// the sweep pointer stays on the victim as the block enters the evict state
	a_victim_unlocked: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SWEEP && fsts.hit |=> state_q == S_EVICT && $stable(fsts.ptr))
		else $error("sweep pointer moved off victim");

	// a result is loaded only when the output register can take it
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_q))
		else $error("stalled result overwritten");

endmodule
`default_nettype wire
